>>> hdl/ppca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppca_pkg
// Shared types and constants of the prefix product count accumulator:
// prime, Barrett constant, word layout, state types and the request and
// response records of the modular multiplier.
// ----------------------------------------------------------------------------
package ppca_pkg;

  localparam int DATA_W  = 30;
  localparam int VALUE_W = 10;
  localparam int EPOCH_W = 8;
  localparam int WORD_W  = DATA_W + EPOCH_W;

  localparam logic [DATA_W-1:0] PRIME = DATA_W'(1000000007);

  // floor(2^60 / prime), below 2^31
  localparam logic [63:0] BARRETT_M_FULL = 64'h1000_0000_0000_0000 / 64'd1000000007;
  localparam logic [31:0] BARRETT_M      = BARRETT_M_FULL[31:0];

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_DECIDE,
    S_QSTEP,
    S_QREAD,
    S_QWAIT,
    S_QADD,
    S_USTART,
    S_ULEAF,
    S_USIB,
    S_UREAD,
    S_UWAIT,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MM_IDLE,
    MM_P1,
    MM_P2,
    MM_P3,
    MM_FIX
  } mm_state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] prod;
  } mm_rsp_t;

endpackage

>>> hdl/ppca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppca_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ppca_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ppca_modmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppca_modmul
// Modular multiplier a*b mod prime. One 32x32 multiplier is used three
// times (product, Barrett quotient estimate, quotient times prime), then a
// final correction. The result appears with done in the correction state.
// ----------------------------------------------------------------------------
module ppca_modmul (
  input  logic              clk,
  input  logic              rst,
  input  ppca_pkg::mm_req_t req,
  output ppca_pkg::mm_rsp_t rsp
);
  import ppca_pkg::*;

  mm_state_t         state;
  mm_state_t         state_next;
  logic [DATA_W-1:0] op_a;
  logic [DATA_W-1:0] op_b;
  logic [31:0]       mult_a;
  logic [31:0]       mult_b;
  logic [63:0]       mul_q;
  logic [31:0]       x_lo;
  logic [31:0]       rem;
  logic [31:0]       rem_sub1;
  logic [31:0]       rem_sub2;
  logic [31:0]       p_ext;
  logic [31:0]       p2_ext;

  assign p_ext  = {2'b00, PRIME};
  assign p2_ext = {1'b0, PRIME, 1'b0};

  always_comb begin
    state_next = state;
    unique case (state)
      MM_IDLE: if (req.start) state_next = MM_P1;
      MM_P1:   state_next = MM_P2;
      MM_P2:   state_next = MM_P3;
      MM_P3:   state_next = MM_FIX;
      MM_FIX:  state_next = MM_IDLE;
      default: state_next = MM_IDLE;
    endcase
  end

  always_comb begin
    mult_a = {2'b00, op_a};
    mult_b = {2'b00, op_b};
    unique case (state)
      MM_P2: begin
        mult_a = mul_q[60:29];
        mult_b = BARRETT_M;
      end
      MM_P3: begin
        mult_a = mul_q[62:31];
        mult_b = p_ext;
      end
      default: begin
        mult_a = {2'b00, op_a};
        mult_b = {2'b00, op_b};
      end
    endcase
  end

  // true remainder lies below three primes, so 32 bits hold it exactly
  assign rem      = x_lo - mul_q[31:0];
  assign rem_sub1 = rem - p_ext;
  assign rem_sub2 = rem - p2_ext;

  always_comb begin
    rsp.done = (state == MM_FIX);
    if (rem >= p2_ext) begin
      rsp.prod = rem_sub2[DATA_W-1:0];
    end else if (rem >= p_ext) begin
      rsp.prod = rem_sub1[DATA_W-1:0];
    end else begin
      rsp.prod = rem[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == MM_IDLE && req.start) begin
      op_a <= req.a;
      op_b <= req.b;
    end
    if (state == MM_P2) begin
      x_lo <= mul_q[31:0];
    end
    mul_q <= mult_a * mult_b;
  end

endmodule

>>> hdl/prefix_product_count_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_product_count_accumulator
// Keeps a binary product tree of per-value counts (one plus count, mod
// prime) and adds the prefix product below each value that lies under the
// running maximum to a running total. One result item per input item.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   in      | in_valid / in_ready  | starts_sequence [0:0], value [9:0]
//   out     | out_valid / out_ready| running_total [29:0]
//
// L = ceil(log2(LEAVES)). An item runs an optional query and then the
// update; each multiplying tree level uses the shared modular multiplier,
// the other levels only step up the tree.
// After reset a clearing pass writes all 2*2^L tree words, one a cycle,
// before the first item; the same pass runs on every 256th sequence start.
// in_ready is high only in idle; a stalled result holds the block before
// it returns to idle.
// ----------------------------------------------------------------------------
module prefix_product_count_accumulator #(
  parameter int LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        starts_sequence,
  input  logic [9:0]  value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] running_total
);
  import ppca_pkg::*;

  localparam int LW    = $clog2(LEAVES);
  localparam int AW    = LW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int CW    = (AW > VALUE_W) ? AW : VALUE_W;

  state_t             state;
  state_t             state_next;
  logic               item_busy;
  logic [EPOCH_W-1:0] epoch;
  logic [VALUE_W-1:0] largest;
  logic [DATA_W-1:0]  total;
  logic [AW-1:0]      clr_addr;
  logic               start_q;
  logic [LW-1:0]      leaf_q;
  logic [VALUE_W-1:0] val_q;
  logic [DATA_W-1:0]  acc;
  logic [DATA_W-1:0]  cur;
  logic [AW-1:0]      idx;

  logic [CW-1:0]      value_ext;
  logic [CW-1:0]      leaf_sat;
  logic               clr_last;
  logic               idx_root;
  logic               epoch_full;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;
  logic [DATA_W-1:0]  node_val;
  logic [DATA_W:0]    leaf_sum;
  logic [DATA_W-1:0]  leaf_inc;
  logic [DATA_W:0]    total_sum;
  logic [DATA_W-1:0]  total_fix;

  mm_req_t            mm_req;
  mm_rsp_t            mm_rsp;

  ppca_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_tree (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ppca_modmul u_modmul (
    .clk(clk),
    .rst(rst),
    .req(mm_req),
    .rsp(mm_rsp)
  );

  // saturate value to the last leaf
  assign value_ext  = CW'(value);
  assign leaf_sat   = (value_ext >= CW'(LEAVES)) ? CW'(LEAVES - 1) : value_ext;
  assign clr_last   = (clr_addr == {AW{1'b1}});
  assign idx_root   = (idx == AW'(1));
  assign epoch_full = (epoch == {EPOCH_W{1'b1}});

  // words of an older sequence read as one
  assign node_val = (ram_rdata[WORD_W-1 -: EPOCH_W] == epoch) ?
                    ram_rdata[DATA_W-1:0] : DATA_W'(1);

  assign leaf_sum  = {1'b0, node_val} + (DATA_W + 1)'(1);
  assign leaf_inc  = (leaf_sum >= {1'b0, PRIME}) ?
                     DATA_W'(leaf_sum - {1'b0, PRIME}) : leaf_sum[DATA_W-1:0];
  assign total_sum = {1'b0, total} + {1'b0, acc};
  assign total_fix = (total_sum >= {1'b0, PRIME}) ?
                     DATA_W'(total_sum - {1'b0, PRIME}) : total_sum[DATA_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_last) state_next = item_busy ? S_DECIDE : S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_PREP;
      S_PREP:   state_next = (start_q && epoch_full) ? S_CLEAR : S_DECIDE;
      S_DECIDE: state_next = (largest > val_q) ? S_QSTEP : S_USTART;
      S_QSTEP: begin
        if (idx_root) begin
          state_next = S_QADD;
        end else if (idx[0]) begin
          state_next = S_QREAD;
        end
      end
      S_QREAD:  state_next = S_QWAIT;
      S_QWAIT:  if (mm_rsp.done) state_next = S_QSTEP;
      S_QADD:   state_next = S_USTART;
      S_USTART: state_next = S_ULEAF;
      S_ULEAF:  state_next = S_USIB;
      S_USIB:   state_next = idx_root ? S_OUT : S_UREAD;
      S_UREAD:  state_next = S_UWAIT;
      S_UWAIT:  if (mm_rsp.done) state_next = S_USIB;
      S_OUT:    if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = {epoch, leaf_inc};
    ram_raddr = '0;
    mm_req    = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = {{EPOCH_W{1'b0}}, DATA_W'(1)};
      end
      S_IDLE:   in_ready = 1'b1;
      S_QSTEP:  ram_raddr = {idx[AW-1:1], 1'b0};
      S_QREAD: begin
        mm_req.start = 1'b1;
        mm_req.a     = acc;
        mm_req.b     = node_val;
      end
      S_USTART: ram_raddr = {1'b1, leaf_q};
      S_ULEAF: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = {epoch, leaf_inc};
      end
      S_USIB:   ram_raddr = {idx[AW-1:1], ~idx[0]};
      S_UREAD: begin
        mm_req.start = 1'b1;
        mm_req.a     = cur;
        mm_req.b     = node_val;
      end
      S_UWAIT: begin
        ram_we    = mm_rsp.done;
        ram_waddr = {1'b0, idx[AW-1:1]};
        ram_wdata = {epoch, mm_rsp.prod};
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      item_busy <= 1'b0;
      epoch     <= '0;
      largest   <= '0;
      total     <= '0;
      out_valid <= 1'b0;
      clr_addr  <= '0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_last) epoch <= '0;
        end
        S_IDLE: begin
          if (in_valid) begin
            start_q   <= starts_sequence;
            leaf_q    <= leaf_sat[LW-1:0];
            val_q     <= leaf_sat[VALUE_W-1:0];
            item_busy <= 1'b1;
          end
        end
        S_PREP: begin
          if (start_q) begin
            largest <= '0;
            total   <= '0;
            if (!epoch_full) epoch <= epoch + EPOCH_W'(1);
          end
        end
        S_DECIDE: begin
          if (largest > val_q) begin
            acc <= DATA_W'(1);
            idx <= {1'b1, leaf_q};
          end else begin
            largest <= val_q;
          end
        end
        S_QSTEP:  if (!idx_root && !idx[0]) idx <= {1'b0, idx[AW-1:1]};
        S_QWAIT: begin
          if (mm_rsp.done) begin
            acc <= mm_rsp.prod;
            idx <= {1'b0, idx[AW-1:1]};
          end
        end
        S_QADD:   total <= total_fix;
        S_USTART: idx <= {1'b1, leaf_q};
        S_ULEAF:  cur <= leaf_inc;
        S_UWAIT: begin
          if (mm_rsp.done) begin
            cur <= mm_rsp.prod;
            idx <= {1'b0, idx[AW-1:1]};
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            running_total <= total;
            item_busy     <= 1'b0;
          end
        end
        default: begin
          item_busy <= item_busy;
        end
      endcase
    end
  end

  a_total_reduced: assert property (@(posedge clk) disable iff (rst)
    total < PRIME)
    else $error("total not reduced");

  a_mm_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    mm_rsp.done |-> (state == S_QWAIT || state == S_UWAIT))
    else $error("multiplier result outside a wait state");

  a_mm_prod_reduced: assert property (@(posedge clk) disable iff (rst)
    mm_rsp.done |-> (mm_rsp.prod < PRIME))
    else $error("multiplier result not reduced");

  a_largest_covers_item: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (largest >= val_q))
    else $error("maximum below current item");

endmodule

>>> dv/prefix_product_count_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_product_count_accumulator_tb
// Drives short directed and random value streams into the accumulator and
// checks every running total against a behavioral model of the leaf counts,
// running maximum and total. Both channels idle and stall at random, with
// one quiet stretch, and the sender drains the block twice before going on.
// ----------------------------------------------------------------------------
module prefix_product_count_accumulator_tb;
  import ppca_pkg::*;

  localparam int NUM_LEAVES  = 1024;
  localparam int RANDOM_ITEMS = 625;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    logic               start;
    logic [VALUE_W-1:0] value;
    bit                 drain;
  } sample_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               starts_sequence = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [DATA_W-1:0]  running_total;

  sample_t           pending[$];
  logic [DATA_W-1:0] totals_due[$];
  logic [DATA_W-1:0] leaf_count [0:NUM_LEAVES-1];
  logic [VALUE_W-1:0] peak_value;
  logic [DATA_W-1:0] sum_mod;
  int                items_taken = 0;
  int                fail_count = 0;
  int                stall_cycles = 0;

  prefix_product_count_accumulator #(.LEAVES(NUM_LEAVES)) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .starts_sequence (starts_sequence),
    .value           (value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .running_total   (running_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] mul_prime(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [63:0] p;
    p = (64'(a) * 64'(b)) % 64'(PRIME);
    return p[DATA_W-1:0];
  endfunction

  function automatic void clear_counts();
    for (int i = 0; i < NUM_LEAVES; i++) leaf_count[i] = DATA_W'(1);
    peak_value = '0;
    sum_mod = '0;
  endfunction

  function automatic logic [DATA_W-1:0] product_below(int v);
    logic [DATA_W-1:0] acc;
    acc = DATA_W'(1);
    for (int i = 0; i < v; i++) acc = mul_prime(acc, leaf_count[i]);
    return acc;
  endfunction

  function automatic logic [DATA_W-1:0] next_total(logic start, logic [VALUE_W-1:0] v_in);
    int          v;
    logic [31:0] s;
    logic [31:0] leaf;
    v = (int'(v_in) >= NUM_LEAVES) ? NUM_LEAVES - 1 : int'(v_in);
    if (start) clear_counts();
    if (int'(peak_value) > v) begin
      s = 32'(sum_mod) + 32'(product_below(v));
      if (s >= 32'(PRIME)) s = s - 32'(PRIME);
      sum_mod = s[DATA_W-1:0];
    end else begin
      peak_value = VALUE_W'(v);
    end
    leaf = 32'(leaf_count[v]) + 32'd1;
    if (leaf >= 32'(PRIME)) leaf = leaf - 32'(PRIME);
    leaf_count[v] = leaf[DATA_W-1:0];
    return sum_mod;
  endfunction

  function automatic bit steady();
    return items_taken >= 380 && items_taken < 500;
  endfunction

  function automatic void add_item(logic start, int v, bit drain);
    sample_t s;
    s.start = start;
    s.value = VALUE_W'(v);
    s.drain = drain;
    pending.push_back(s);
  endfunction

  // driver
  always @(posedge clk) begin : drive_proc
    sample_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        totals_due.push_back(next_total(starts_sequence, value));
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && (!pending[0].drain || totals_due.size() == 0) &&
            (steady() || $urandom_range(0, 99) >= 13)) begin
          nxt = pending.pop_front();
          in_valid <= 1'b1;
          starts_sequence <= nxt.start;
          value <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor_proc
    logic [DATA_W-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (totals_due.size() == 0) begin
          $error("running_total expected none actual %0d", running_total);
          fail_count++;
        end else begin
          want = totals_due.pop_front();
          if (running_total !== want) begin
            $error("running_total expected %0d actual %0d", want, running_total);
            fail_count++;
          end
        end
      end
      out_ready <= steady() || ($urandom_range(0, 99) >= 13);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int len;
    clear_counts();

    // directed
    add_item(1'b0, 0, 1'b0);
    add_item(1'b0, 1023, 1'b0);
    add_item(1'b0, 0, 1'b0);
    add_item(1'b0, 1023, 1'b0);
    add_item(1'b0, 1022, 1'b0);
    add_item(1'b0, 1, 1'b0);
    add_item(1'b0, 1, 1'b0);
    add_item(1'b0, 2, 1'b0);
    add_item(1'b0, 512, 1'b0);
    add_item(1'b0, 'h2AA, 1'b0);
    add_item(1'b0, 'h155, 1'b0);
    add_item(1'b0, 0, 1'b0);
    add_item(1'b1, 0, 1'b0);
    add_item(1'b0, 0, 1'b0);
    add_item(1'b1, 1023, 1'b0);
    add_item(1'b0, 1023, 1'b0);
    add_item(1'b0, 1000, 1'b0);
    add_item(1'b0, 0, 1'b0);
    add_item(1'b1, 5, 1'b0);
    add_item(1'b0, 3, 1'b0);
    add_item(1'b0, 3, 1'b0);
    add_item(1'b0, 4, 1'b0);
    add_item(1'b0, 5, 1'b0);

    // random sequences, then a run of one-item sequences to wrap the start count
    n = 0;
    while (n < RANDOM_ITEMS - 260) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        add_item((i == 0) ? 1'b1 : ($urandom_range(0, 99) < 3), 
                 ($urandom_range(0, 1) != 0) ? $urandom_range(0, 31) : $urandom_range(0, 1023),
                 n == 1 || n == 250);
        n++;
      end
    end
    for (int i = 0; i < 260; i++) begin
      add_item(1'b1, $urandom_range(0, 1023), 1'b0);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (!(pending.size() == 0 && !in_valid && totals_due.size() == 0)) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && totals_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
